// ===== rtl/mrfp_pkg.sv =====
// ----------------------------------------------------------------------------
// mrfp_pkg
// Shared types and constants of the six-neighbourhood prior estimator.
// ----------------------------------------------------------------------------
package mrfp_pkg;

  localparam int BINS_PER_CLASS = 2401;   // 7^4 neighbour configurations
  localparam int NUM_DIGITS     = 4;      // count digits for classes 2 to 5
  localparam int DIGIT_RADIX    = 7;      // 0..6 neighbours per class
  localparam int NEIGHBOURS     = 6;
  localparam int DIV_W          = 64;
  localparam int VALUE_W        = 48;
  localparam int LOG_FRAC       = 16;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_V_WR,
    S_FR_START,
    S_FR_DIV,
    S_FR_OUT,
    S_SW_INIT,
    S_B_RD,
    S_B_CHK,
    S_LOG_NORM,
    S_LOG_SQ,
    S_LN_MUL,
    S_PD_MUL,
    S_NEXT,
    S_BT_START,
    S_BT_DIV,
    S_BT_OUT
  } state_t;

  typedef enum logic [1:0] {
    REG_NUM_CLASSES = 2'd0,
    REG_UNIT_ALPHA  = 2'd1,
    REG_COUNT_THR   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_VOXEL  = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef enum logic {
    KIND_FRACTION = 1'b0,
    KIND_BETA     = 1'b1
  } kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

// ===== rtl/mrfp_div.sv =====
// ----------------------------------------------------------------------------
// mrfp_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mrfp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [mrfp_pkg::DIV_W-1:0]  dividend,
  input  logic [mrfp_pkg::DIV_W-1:0]  divisor,
  output logic [mrfp_pkg::DIV_W-1:0]  quotient,
  output mrfp_pkg::div_sts_t          sts
);
  import mrfp_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [DIV_W:0]   trial;
  logic             ge;
  logic [DIV_W:0]   diff;

  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    ge    = trial >= {1'b0, dsr};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign quotient = quo;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

// ===== rtl/mrf_neighbour_config_prior_estimator.sv =====
// ----------------------------------------------------------------------------
// mrf_neighbour_config_prior_estimator
// Histogram of six-neighbour class configurations with a finish pass that
// reports class fractions and a log-ratio regression estimate of beta.
// ----------------------------------------------------------------------------
//  channel  | signals                       | role
//  ---------+-------------------------------+--------------------------------
//  in       | in_valid / in_ready           | voxel sample or finish request
//  out      | out_valid / out_ready         | fraction and beta results
//  cfg      | cfg_we, cfg_index, cfg_data   | register writes, no handshake
//
//  a voxel request reads its histogram entry in S_IDLE and writes it back in S_V_WR
//  finish: each fraction runs on the serial divider (skipped in unit mode or for
//  an empty volume), then each bin and class pair is read and checked, and a
//  pair that passes goes through normalise and 16 squarings per log,
//  then beta runs on the serial divider
//  after reset and after each finish the MAX_CLASSES*2401 histogram entries are
//  cleared one entry a cycle, with in_ready low
//  a result waiting in the output register stalls only the sequencer
// ----------------------------------------------------------------------------
module mrf_neighbour_config_prior_estimator #(
  parameter int MAX_CLASSES = 5,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [7:0]                        centre_label,
  input  logic [7:0]                        left_label,
  input  logic [7:0]                        right_label,
  input  logic [7:0]                        front_label,
  input  logic [7:0]                        back_label,
  input  logic [7:0]                        below_label,
  input  logic [7:0]                        above_label,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              kind,
  output logic [2:0]                        class_index,
  output logic signed [mrfp_pkg::VALUE_W-1:0] value,
  output logic                              error,
  output logic                              last,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [15:0]                       cfg_data
);
  import mrfp_pkg::*;

  localparam int CW         = COUNT_WIDTH;
  localparam int HIST_DEPTH = MAX_CLASSES * BINS_PER_CLASS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int K_W        = $clog2(CW);
  localparam int LOG_W      = K_W + LOG_FRAC;
  localparam int CIDX_W     = $clog2(MAX_CLASSES);
  localparam int T_W        = $clog2(BINS_PER_CLASS);

  state_t state, state_next;

  // configuration
  logic [2:0]  num_classes;
  logic        unit_alpha_mode;
  logic [15:0] count_threshold;
  logic [2:0]  nc;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes     <= 3'd3;
      unit_alpha_mode <= 1'b0;
      count_threshold <= 16'd5;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NUM_CLASSES: num_classes     <= cfg_data[2:0];
        REG_UNIT_ALPHA:  unit_alpha_mode <= cfg_data[0];
        REG_COUNT_THR:   count_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  assign nc = (int'(num_classes) > MAX_CLASSES) ? 3'(MAX_CLASSES) : num_classes;

  // voxel address
  logic [7:0]         nb [NEIGHBOURS];
  logic [2:0]         fdig [NUM_DIGITS];
  logic               c_ok;
  logic [2:0]         c_idx;
  logic [HIST_AW-1:0] vox_addr;

  assign nb[0] = left_label;
  assign nb[1] = right_label;
  assign nb[2] = front_label;
  assign nb[3] = back_label;
  assign nb[4] = below_label;
  assign nb[5] = above_label;

  always_comb begin
    for (int g = 0; g < NUM_DIGITS; g++) begin
      fdig[g] = 3'd0;
      if (g + 2 <= int'(nc)) begin
        for (int n = 0; n < NEIGHBOURS; n++) begin
          if (nb[n] == 8'(g + 2)) fdig[g] = fdig[g] + 3'd1;
        end
      end
    end
    c_ok     = (centre_label != 8'd0) && (centre_label <= {5'd0, nc});
    c_idx    = centre_label[2:0] - 3'd1;
    vox_addr = HIST_AW'(int'(c_idx) * BINS_PER_CLASS
                        + int'(fdig[0]) * 343 + int'(fdig[1]) * 49
                        + int'(fdig[2]) * DIGIT_RADIX + int'(fdig[3]));
  end

  // histogram memory
  logic [CW-1:0]      hist [HIST_DEPTH];
  logic [CW-1:0]      rd_a, rd_b;
  logic [HIST_AW-1:0] addr_a, addr_b, waddr;
  logic [CW-1:0]      wdata;
  logic               mem_we;
  logic [HIST_AW-1:0] vox_addr_r;
  logic [HIST_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (mem_we) hist[waddr] <= wdata;
    rd_a <= hist[addr_a];
    rd_b <= hist[addr_b];
  end

  // totals
  logic [CW-1:0] voxel_total;
  logic [CW-1:0] class_totals [MAX_CLASSES];

  // sweep state
  logic [T_W-1:0]      t;
  logic [2:0]          dig [NUM_DIGITS];
  logic [2:0]          pi, pj;
  logic [4:0]          dsum;
  logic signed [5:0]   fi, fj;
  logic signed [6:0]   d;
  logic [4:0]          dmag;
  logic                last_pair;
  logic [47:0]         sum_squared_diff;
  logic signed [63:0]  sum_log_product;

  always_comb begin
    dsum = 5'(dig[0]) + 5'(dig[1]) + 5'(dig[2]) + 5'(dig[3]);
    fi   = $signed({3'd0, dig[2'(pi - 3'd1)]});
    fj   = (pj == 3'd0) ? (6'sd6 - $signed({1'b0, dsum}))
                        : $signed({3'd0, dig[2'(pj - 3'd1)]});
    d    = {fi[5], fi} - {fj[5], fj};
    dmag = d[6] ? 5'(-d) : 5'(d);
    last_pair = (pj + 3'd1 == pi) && (pi + 3'd1 == nc);
  end

  // log unit registers
  logic [CW-1:0]      lx;
  logic [CW-1:0]      cj_r;
  logic [K_W-1:0]     lk;
  logic [30:0]        m;
  logic [LOG_W-1:0]   r;
  logic [3:0]         b;
  logic               which;
  logic [LOG_W-1:0]   log_i, log_j;
  logic [31:0]        p_r;
  logic               ln_neg;
  logic [CW+30:0]     mant_ext;
  logic [31:0]        sq;
  logic [LOG_W-1:0]   r_upd;
  logic [LOG_W:0]     ld;
  logic [LOG_W:0]     ld_mag;
  logic [64:0]        p_round;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mant_ext = {lx, 31'd0};
    ld       = {1'b0, log_i} - {1'b0, log_j};
    ld_mag   = ld[LOG_W] ? -ld : ld;
    unique case (state)
      S_LOG_SQ: begin
        mul_a = {1'b0, m};
        mul_b = {1'b0, m};
      end
      S_LN_MUL: begin
        mul_a = 32'(ld_mag);
        mul_b = LN2_Q32;
      end
      default: begin
        mul_a = p_r;
        mul_b = 32'(dmag);
      end
    endcase
    mul_p   = mul_a * mul_b;
    sq      = mul_p[61:30];
    r_upd   = r;
    if (sq[31]) r_upd[b] = 1'b1;
    p_round = {1'b0, mul_p} + (65'd1 << 31);
  end

  // divider
  logic [DIV_W-1:0] div_dividend, div_divisor, div_q;
  logic             div_start;
  div_sts_t         div_sts;
  logic [63:0]      slp_mag;
  logic [63:0]      beta_num;
  logic [2:0]       fcnt;

  always_comb begin
    slp_mag  = sum_log_product[63] ? 64'(-sum_log_product) : 64'(sum_log_product);
    beta_num = {sum_squared_diff[31:0], 32'd0};
    if (state == S_BT_START) begin
      div_dividend = beta_num + (slp_mag >> 1);
      div_divisor  = slp_mag;
    end else begin
      div_dividend = DIV_W'({class_totals[CIDX_W'(fcnt)], 16'd0}) + DIV_W'(voxel_total >> 1);
      div_divisor  = DIV_W'(voxel_total);
    end
  end

  mrfp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .sts      (div_sts)
  );

  // result staging
  logic [VALUE_W-1:0] res_val;
  logic               res_err;
  logic [VALUE_W-1:0] beta_sat;

  always_comb begin
    beta_sat = (div_q[DIV_W-1:VALUE_W-1] != '0) ? {1'b0, {(VALUE_W-1){1'b1}}}
                                                : div_q[VALUE_W-1:0];
  end

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == {CW{1'b1}}) ? v : v + CW'(1);
  endfunction

  assign in_ready = (state == S_IDLE);

  // sequencer
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    mem_we     = 1'b0;
    waddr      = vox_addr_r;
    wdata      = sat_inc(rd_a);
    addr_a     = vox_addr;
    addr_b     = HIST_AW'(int'(pj) * BINS_PER_CLASS + int'(t));
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        waddr  = clr_addr;
        wdata  = '0;
        if (clr_addr == HIST_AW'(HIST_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (op_t'(op) == OP_FINISH) state_next = (nc == 3'd0) ? S_SW_INIT : S_FR_START;
          else if (c_ok)              state_next = S_V_WR;
        end
      end
      S_V_WR: begin
        mem_we     = 1'b1;
        state_next = S_IDLE;
      end
      S_FR_START: begin
        if (unit_alpha_mode || voxel_total == '0) state_next = S_FR_OUT;
        else begin
          div_start  = 1'b1;
          state_next = S_FR_DIV;
        end
      end
      S_FR_DIV:   if (div_sts.done) state_next = S_FR_OUT;
      S_FR_OUT: begin
        if (!out_valid) state_next = (fcnt + 3'd1 == nc) ? S_SW_INIT : S_FR_START;
      end
      S_SW_INIT:  state_next = (nc < 3'd2) ? S_BT_START : S_B_RD;
      S_B_RD: begin
        addr_a     = HIST_AW'(int'(pi) * BINS_PER_CLASS + int'(t));
        state_next = S_B_CHK;
      end
      S_B_CHK: begin
        if (rd_a < CW'(count_threshold) || rd_b < CW'(count_threshold)
            || rd_a == '0 || rd_b == '0) state_next = S_NEXT;
        else state_next = S_LOG_NORM;
      end
      S_LOG_NORM: if (lx[CW-1]) state_next = S_LOG_SQ;
      S_LOG_SQ: begin
        if (b == 4'd0) state_next = which ? S_LN_MUL : S_LOG_NORM;
      end
      S_LN_MUL:   state_next = S_PD_MUL;
      S_PD_MUL:   state_next = S_NEXT;
      S_NEXT: begin
        if (last_pair && t == T_W'(BINS_PER_CLASS - 1)) state_next = S_BT_START;
        else state_next = S_B_RD;
      end
      S_BT_START: begin
        if (sum_log_product == '0) state_next = S_BT_OUT;
        else begin
          div_start  = 1'b1;
          state_next = S_BT_DIV;
        end
      end
      S_BT_DIV:   if (div_sts.done) state_next = S_BT_OUT;
      S_BT_OUT:   if (!out_valid) state_next = S_CLEAR;
      default:    state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  // control counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      out_valid   <= 1'b0;
      voxel_total <= '0;
      for (int k = 0; k < MAX_CLASSES; k++) class_totals[k] <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLEAR: clr_addr <= clr_addr + HIST_AW'(1);
        S_IDLE: begin
          if (in_valid && op_t'(op) == OP_VOXEL && c_ok) begin
            voxel_total                 <= sat_inc(voxel_total);
            class_totals[CIDX_W'(c_idx)] <= sat_inc(class_totals[CIDX_W'(c_idx)]);
          end
        end
        S_FR_OUT: if (!out_valid) out_valid <= 1'b1;
        S_BT_OUT: begin
          if (!out_valid) begin
            out_valid   <= 1'b1;
            clr_addr    <= '0;
            voxel_total <= '0;
            for (int k = 0; k < MAX_CLASSES; k++) class_totals[k] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        vox_addr_r <= vox_addr;
        fcnt       <= 3'd0;
      end
      S_FR_START: begin
        res_val <= unit_alpha_mode ? VALUE_W'(65536) : '0;
        res_err <= !unit_alpha_mode && (voxel_total == '0);
      end
      S_FR_DIV: if (div_sts.done) res_val <= div_q[VALUE_W-1:0];
      S_FR_OUT: begin
        if (!out_valid) begin
          kind        <= KIND_FRACTION;
          class_index <= fcnt;
          value       <= res_val;
          error       <= res_err;
          last        <= 1'b0;
          fcnt        <= fcnt + 3'd1;
        end
      end
      S_SW_INIT: begin
        t                <= '0;
        for (int g = 0; g < NUM_DIGITS; g++) dig[g] <= 3'd0;
        pi               <= 3'd1;
        pj               <= 3'd0;
        sum_squared_diff <= '0;
        sum_log_product  <= '0;
      end
      S_B_CHK: begin
        lx    <= rd_a;
        cj_r  <= rd_b;
        lk    <= K_W'(CW - 1);
        which <= 1'b0;
      end
      S_LOG_NORM: begin
        if (lx[CW-1]) begin
          m <= mant_ext[CW+30:CW];
          r <= {lk, 16'd0};
          b <= 4'd15;
        end else begin
          lx <= {lx[CW-2:0], 1'b0};
          lk <= lk - K_W'(1);
        end
      end
      S_LOG_SQ: begin
        m <= sq[31] ? sq[31:1] : sq[30:0];
        r <= r_upd;
        b <= b - 4'd1;
        if (b == 4'd0) begin
          if (!which) begin
            log_i <= r_upd;
            lx    <= cj_r;
            lk    <= K_W'(CW - 1);
            which <= 1'b1;
          end else begin
            log_j <= r_upd;
          end
        end
      end
      S_LN_MUL: begin
        p_r    <= p_round[63:32];
        ln_neg <= ld[LOG_W];
      end
      S_PD_MUL: begin
        sum_squared_diff <= sum_squared_diff + 48'({5'd0, dmag} * {5'd0, dmag});
        // sign of the product follows the log ratio and the digit difference
        if (ln_neg ^ d[6]) sum_log_product <= sum_log_product - $signed(mul_p);
        else               sum_log_product <= sum_log_product + $signed(mul_p);
      end
      S_NEXT: begin
        if (pj + 3'd1 != pi) pj <= pj + 3'd1;
        else if (pi + 3'd1 != nc) begin
          pi <= pi + 3'd1;
          pj <= 3'd0;
        end else begin
          pi <= 3'd1;
          pj <= 3'd0;
          t  <= t + T_W'(1);
          // base-7 odometer tracks the digits of t
          if (dig[3] != 3'd6) dig[3] <= dig[3] + 3'd1;
          else begin
            dig[3] <= 3'd0;
            if (dig[2] != 3'd6) dig[2] <= dig[2] + 3'd1;
            else begin
              dig[2] <= 3'd0;
              if (dig[1] != 3'd6) dig[1] <= dig[1] + 3'd1;
              else begin
                dig[1] <= 3'd0;
                dig[0] <= dig[0] + 3'd1;
              end
            end
          end
        end
      end
      S_BT_START: begin
        res_val <= '0;
        res_err <= (sum_log_product == '0);
      end
      S_BT_DIV: begin
        if (div_sts.done) res_val <= sum_log_product[63] ? -beta_sat : beta_sat;
      end
      S_BT_OUT: begin
        if (!out_valid) begin
          kind        <= KIND_BETA;
          class_index <= 3'd0;
          value       <= res_val;
          error       <= res_err;
          last        <= 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/mrfp_chk.sv =====
// ----------------------------------------------------------------------------
// mrfp_chk
// Port-level checks on the prior estimator, bound to the top level.
// ----------------------------------------------------------------------------
module mrfp_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic                               kind,
  input logic [2:0]                         class_index,
  input logic signed [mrfp_pkg::VALUE_W-1:0] value,
  input logic                               error,
  input logic                               last
);
  import mrfp_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(last))
    else $error("stalled result changed");

  // histogram clear follows reset
  a_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("request taken during clear");

  // run ends on beta
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == KIND_BETA)) && (!last || class_index == 3'd0))
    else $error("last not on beta result");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> value == '0)
    else $error("error result with nonzero value");

endmodule

bind mrf_neighbour_config_prior_estimator mrfp_chk u_chk (.*);

// ===== tb/mrf_neighbour_config_prior_estimator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrf_neighbour_config_prior_estimator_tb
// Streams voxel requests and finish requests through the estimator over a
// series of register settings. A scoreboard class keeps its own histogram and
// predicts every fraction and beta result, which are checked in order.
// ----------------------------------------------------------------------------
module mrf_neighbour_config_prior_estimator_tb;
  import mrfp_pkg::*;

  localparam int HIST_BINS = 5 * BINS_PER_CLASS;
  localparam int STALL_LIMIT = 1000000;

  typedef struct {
    logic        kind;
    logic [2:0]  cls;
    logic [47:0] val;
    logic        err;
    logic        fin;
  } prior_result_t;

  class prior_scoreboard;
    prior_result_t    awaited[$];
    int unsigned      n_classes;
    bit               unit_mode;
    int unsigned      threshold;
    longint unsigned  hist[HIST_BINS];
    longint unsigned  total;
    longint unsigned  per_class[5];
    int               mismatches;

    function void clear_counts();
      foreach (hist[i]) hist[i] = 0;
      foreach (per_class[i]) per_class[i] = 0;
      total = 0;
    endfunction

    function longint unsigned bump(longint unsigned v);
      return (v >= 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v + 1;
    endfunction

    function longint log2_q16(longint unsigned x);
      int k;
      longint unsigned m;
      longint r;
      k = 0;
      while (k < 63 && (x >> (k + 1)) != 0) k++;
      m = (k <= 30) ? (x << (30 - k)) : (x >> (k - 30));
      r = longint'(k) << 16;
      for (int b = 15; b >= 0; b--) begin
        m = (m * m) >> 30;
        if (m >= (64'd2 << 30)) begin
          r |= longint'(1) << b;
          m >>= 1;
        end
      end
      return r;
    endfunction

    function longint ln_ratio(longint unsigned a, longint unsigned b);
      longint d;
      longint unsigned mag, p;
      d = log2_q16(a) - log2_q16(b);
      mag = (d < 0) ? longint'(-d) : d;
      p = (mag * 64'd2977044472 + (64'd1 << 31)) >> 32;
      return (d < 0) ? -longint'(p) : longint'(p);
    endfunction

    function void push(logic k, int c, logic [47:0] v, logic e, logic f);
      prior_result_t r;
      r.kind = k; r.cls = 3'(c); r.val = v; r.err = e; r.fin = f;
      awaited.push_back(r);
    endfunction

    function void note_request(logic op_i, logic [7:0] c, logic [7:0] nb[6]);
      int unsigned nc, idx;
      int unsigned dg[4];
      longint unsigned ssd, den, num, q;
      longint slp;
      nc = (n_classes > 5) ? 5 : n_classes;
      if (op_i == OP_VOXEL) begin
        if (c == 0 || c > nc) return;
        dg = '{0, 0, 0, 0};
        for (int i = 2; i <= nc; i++)
          foreach (nb[j]) if (nb[j] == i) dg[i-2]++;
        idx = (c - 1) * BINS_PER_CLASS + dg[0] * 343 + dg[1] * 49 + dg[2] * 7 + dg[3];
        hist[idx] = bump(hist[idx]);
        total = bump(total);
        per_class[c-1] = bump(per_class[c-1]);
        return;
      end
      for (int i = 0; i < nc; i++) begin
        if (unit_mode) push(KIND_FRACTION, i, 48'd65536, 1'b0, 1'b0);
        else if (total == 0) push(KIND_FRACTION, i, 48'd0, 1'b1, 1'b0);
        else push(KIND_FRACTION, i, 48'((per_class[i] * 65536 + total / 2) / total),
                  1'b0, 1'b0);
      end
      ssd = 0;
      slp = 0;
      for (int t = 0; t < BINS_PER_CLASS; t++) begin
        int s, fi, fj, d;
        int g[4];
        g[0] = t / 343; g[1] = (t / 49) % 7; g[2] = (t / 7) % 7; g[3] = t % 7;
        s = g[0] + g[1] + g[2] + g[3];
        for (int i = 0; i < nc; i++)
          for (int j = 0; j < i; j++) begin
            longint unsigned ci, cj;
            ci = hist[i * BINS_PER_CLASS + t];
            cj = hist[j * BINS_PER_CLASS + t];
            if (ci < threshold || cj < threshold || ci == 0 || cj == 0) continue;
            fi = (i == 0) ? 6 - s : g[i-1];
            fj = (j == 0) ? 6 - s : g[j-1];
            d = fi - fj;
            ssd += 64'(d * d);
            slp += ln_ratio(ci, cj) * d;
          end
      end
      if (slp == 0) push(KIND_BETA, 0, 48'd0, 1'b1, 1'b1);
      else begin
        den = (slp < 0) ? longint'(-slp) : slp;
        num = ssd << 32;
        q = (num + den / 2) / den;
        if (q > 64'h7FFF_FFFF_FFFF) q = 64'h7FFF_FFFF_FFFF;
        push(KIND_BETA, 0, (slp < 0) ? 48'(0 - q) : 48'(q), 1'b0, 1'b1);
      end
      clear_counts();
    endfunction

    function void check_result(logic k, logic [2:0] c, logic [47:0] v, logic e, logic f);
      prior_result_t x;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result kind=%0d class=%0d value=%h err=%0d last=%0d",
                   k, c, v, e, f);
        return;
      end
      x = awaited.pop_front();
      if (x.kind !== k || x.cls !== c || x.val !== v || x.err !== e || x.fin !== f) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"result mismatch: exp kind=%0d class=%0d value=%h err=%0d last=%0d,",
                    " got kind=%0d class=%0d value=%h err=%0d last=%0d"},
                   x.kind, x.cls, x.val, x.err, x.fin, k, c, v, e, f);
      end
    endfunction
  endclass

  logic               clk, rst;
  logic               in_valid, in_ready, op;
  logic [7:0]         centre_label, left_label, right_label, front_label;
  logic [7:0]         back_label, below_label, above_label;
  logic               out_valid, out_ready, kind, error, last;
  logic [2:0]         class_index;
  logic signed [47:0] value;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  prior_scoreboard sb = new();
  bit calm;
  int stall_cycles;
  logic [7:0] shapes[4][6];

  mrf_neighbour_config_prior_estimator u_top (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // result side and watchdog
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (out_valid && out_ready)
        sb.check_result(kind, class_index, value, error, last);
      if ((out_valid && out_ready) || (in_valid && in_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles > STALL_LIMIT) begin
        $display("mrf_neighbour_config_prior_estimator_tb: errors");
        $finish;
      end
      out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 32);
    end
  end

  task automatic send_request(logic op_i, logic [7:0] c, logic [7:0] nb[6]);
    while (!calm && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= op_i;
    centre_label <= c;
    left_label <= nb[0]; right_label <= nb[1]; front_label <= nb[2];
    back_label <= nb[3]; below_label <= nb[4]; above_label <= nb[5];
    do @(posedge clk); while (!in_ready);
    sb.note_request(op_i, c, nb);
  endtask

  task automatic finish_volume();
    logic [7:0] nb[6];
    foreach (nb[i]) nb[i] = 8'($urandom_range(0, 255));
    send_request(OP_FINISH, 8'($urandom_range(0, 255)), nb);
  endtask

  // wait for every result, let the clear pass run, then in_ready comes back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [15:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_NUM_CLASSES: sb.n_classes = data[2:0];
      REG_UNIT_ALPHA:  sb.unit_mode = data[0];
      default:         sb.threshold = data;
    endcase
  endtask

  task automatic set_regs(int nc, bit unit, int thr);
    settle();
    write_reg(REG_NUM_CLASSES, 16'(nc));
    write_reg(REG_UNIT_ALPHA, 16'(unit));
    write_reg(REG_COUNT_THR, 16'(thr));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_volume(int n_vox);
    int nc;
    logic [7:0] nb[6];
    logic [7:0] c;
    nc = (sb.n_classes > 5) ? 5 : sb.n_classes;
    foreach (shapes[p, q]) shapes[p][q] = 8'($urandom_range(0, nc + 1));
    for (int v = 0; v < n_vox; v++) begin
      c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(1, nc + 0));
      if ($urandom_range(0, 99) < 85) nb = shapes[$urandom_range(0, 3)];
      else foreach (nb[i]) nb[i] = $urandom_range(0, 1) ? 8'($urandom_range(0, 255))
                                                         : 8'($urandom_range(0, 7));
      send_request(OP_VOXEL, c, nb);
    end
    finish_volume();
  endtask

  initial begin
    logic [7:0] nb[6];
    calm = 1'b0;
    rst <= 1'b1;
    in_valid <= 1'b0;
    op <= OP_VOXEL;
    {centre_label, left_label, right_label, front_label} <= '0;
    {back_label, below_label, above_label} <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_NUM_CLASSES;
    cfg_data <= '0;
    sb.n_classes = 3;
    sb.unit_mode = 0;
    sb.threshold = 5;
    sb.mismatches = 0;
    sb.clear_counts();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty volume straight after reset, default registers
    finish_volume();
    set_regs(3, 0, 1);
    // background, out of range centres and odd neighbour labels
    nb = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd255};
    send_request(OP_VOXEL, 8'd0, nb);
    send_request(OP_VOXEL, 8'd255, nb);
    send_request(OP_VOXEL, 8'd4, nb);
    for (int r = 0; r < 3; r++)
      for (int c = 1; c <= 3; c++) send_request(OP_VOXEL, 8'(c), nb);
    nb = '{8'd3, 8'd3, 8'd3, 8'd3, 8'd3, 8'd3};
    for (int c = 1; c <= 3; c++) send_request(OP_VOXEL, 8'(c), nb);
    nb = '{8'd2, 8'd2, 8'd2, 8'd2, 8'd2, 8'd2};
    for (int c = 1; c <= 3; c++) send_request(OP_VOXEL, 8'(c), nb);
    finish_volume();
    // class count zero skips every voxel and fraction, leaving only the beta result
    set_regs(0, 0, 0);
    nb = '{8'd1, 8'd1, 8'd0, 8'd0, 8'd1, 8'd1};
    send_request(OP_VOXEL, 8'd1, nb);
    finish_volume();

    set_regs(5, 0, 0);
    random_volume(80);
    set_regs(7, 1, 2);
    calm = 1'b1;
    random_volume(90);
    calm = 1'b0;
    set_regs(2, 0, 3);
    random_volume(70);
    set_regs(1, 1, 65535);
    random_volume(30);
    set_regs(4, 0, 1);
    random_volume(80);
    set_regs(3, 0, 0);
    random_volume(60);

    settle();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.awaited.size() == 0)
      $display("mrf_neighbour_config_prior_estimator_tb: clean");
    else
      $display("mrf_neighbour_config_prior_estimator_tb: errors");
    $finish;
  end
endmodule
